[rtl/vdi_pkg.sv]
// Shared types and constants of the vertex dedup indexer.
package vdi_pkg;

  // Key: eight 32-bit float patterns side by side
  localparam int unsigned KEY_W   = 256;
  // Output vertex index width
  localparam int unsigned IDX_W   = 16;
  // Mesh epoch tag width; epoch 0 marks an empty slot
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND = 2'd0;
  localparam logic [1:0] STATUS_NEW   = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // One table slot as stored in the RAM
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [IDX_W-1:0]   index;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // One result word
  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic [1:0]       status;
  } result_t;

  // Lookup sequencer states
  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SWEEP  = 7'b0000100,
    S_PROBE  = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_e;

endpackage

[rtl/vdi_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vdi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/vdi_out_reg.sv]
// Output holding register between the lookup sequencer and the result channel.
module vdi_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ld_valid_i,
  input  vdi_pkg::result_t  ld_data_i,
  output logic              ld_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       vertex_index_o,
  output logic [1:0]        status_o
);

  logic             valid_q, valid_d;
  vdi_pkg::result_t data_q;

  // free when empty or the held word leaves this cycle
  assign ld_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ld_valid_i && ld_ready_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ld_valid_i && ld_ready_o) begin
      data_q <= ld_data_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign vertex_index_o = data_q.vertex_index;
  assign status_o       = data_q.status;

endmodule

[rtl/vertex_dedup_indexer.sv]
// Vertex dedup indexer: open-addressed hash table of vertex keys per mesh.
//
// Each input word is one vertex (eight raw float patterns); the block returns the
// index of an identical vertex seen earlier in the current mesh (status 0), or
// assigns the next global index and records the vertex (status 1), or reports
// full (status 2, index 0) when the table or the index space is used up. The
// table is a single RAM with one read and one write per cycle and registered
// read data; lookups use linear probing from a folded hash of the key, and
// each probe reads a slot (S_PROBE), then compares its tag and key (S_CHECK).
// A new vertex is then written into the empty slot (S_WRITE) before the result.
// A start-of-mesh word bumps an 8-bit epoch tag instead of clearing the table;
// after reset, and on every 255th start of mesh when the tag wraps, a clearing
// pass over all TABLE_ENTRIES slots rewrites the slot tags before the lookup
// proceeds. No input word is taken during the pass after reset. Index
// numbering continues across meshes.
module vertex_dedup_indexer #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned INDEX_LIMIT   = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_of_mesh_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] tex_u_i,
  input  logic [31:0] tex_v_i,
  input  logic [31:0] norm_x_i,
  input  logic [31:0] norm_y_i,
  input  logic [31:0] norm_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] vertex_index_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned NW = $clog2(INDEX_LIMIT + 1);
  localparam int unsigned EW = $bits(vdi_pkg::entry_t);
  localparam logic [CW-1:0] TABLE_FULL  = CW'(TABLE_ENTRIES);
  localparam logic [NW-1:0] INDEX_END   = NW'(INDEX_LIMIT);
  localparam logic [AW-1:0] LAST_ADDR   = AW'(TABLE_ENTRIES - 1);
  localparam logic [AW:0]   TABLE_SIZE  = (AW + 1)'(TABLE_ENTRIES);

  vdi_pkg::state_e state_q, state_d;

  logic [vdi_pkg::KEY_W-1:0]   key_c, key_q;
  logic [AW-1:0]               fold_c, home_c, home_q;
  logic [AW:0]                 fold_ext;
  logic [AW-1:0]               addr_q, addr_d, addr_inc;
  logic [CW-1:0]               probes_q, probes_d, probes_inc;
  logic [CW-1:0]               count_q, count_d;
  logic [NW-1:0]               next_q, next_d;
  logic [vdi_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  vdi_pkg::result_t            res_q, res_d;

  logic             accept;
  logic             ram_wr_en, ram_rd_en;
  vdi_pkg::entry_t  ram_wr_data, ram_rd_data;
  logic             slot_used, slot_hit;
  logic             ld_ready;

  assign key_c = {pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i,
                  norm_x_i, norm_y_i, norm_z_i};

  // home slot: xor fold of the key, reduced once into the table range
  always_comb begin
    fold_c = '0;
    for (int b = 0; b < vdi_pkg::KEY_W; b++) begin
      fold_c[b % AW] = fold_c[b % AW] ^ key_c[b];
    end
    fold_ext = {1'b0, fold_c};
    if (fold_ext >= TABLE_SIZE) begin
      fold_ext = fold_ext - TABLE_SIZE;
    end
    home_c = fold_ext[AW-1:0];
  end

  assign in_stall_o = (state_q != vdi_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign addr_inc   = (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
  assign probes_inc = probes_q + CW'(1);

  // slot compare on the word read in the previous cycle
  assign slot_used = (ram_rd_data.epoch == epoch_q);
  assign slot_hit  = slot_used && (ram_rd_data.key == key_q);

  // lookup sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    probes_d    = probes_q;
    count_d     = count_q;
    next_d      = next_q;
    epoch_d     = epoch_q;
    res_d       = res_q;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_data = '0;
    unique case (state_q) inside
      vdi_pkg::S_INIT, vdi_pkg::S_SWEEP: begin
        // clear slot tags, one slot a cycle
        ram_wr_en         = 1'b1;
        ram_wr_data.epoch = vdi_pkg::EPOCH_EMPTY;
        addr_d            = addr_inc;
        if (addr_q == LAST_ADDR) begin
          epoch_d = vdi_pkg::EPOCH_FIRST;
          if (state_q == vdi_pkg::S_INIT) begin
            state_d = vdi_pkg::S_IDLE;
          end else begin
            addr_d  = home_q;
            state_d = vdi_pkg::S_PROBE;
          end
        end
      end
      vdi_pkg::S_IDLE: begin
        if (accept) begin
          addr_d   = home_c;
          probes_d = '0;
          state_d  = vdi_pkg::S_PROBE;
          if (start_of_mesh_i) begin
            count_d = '0;
            if (epoch_q == vdi_pkg::EPOCH_LAST) begin
              addr_d  = '0;
              state_d = vdi_pkg::S_SWEEP;
            end else begin
              epoch_d = epoch_q + vdi_pkg::EPOCH_W'(1);
            end
          end
        end
      end
      vdi_pkg::S_PROBE: begin
        ram_rd_en = 1'b1;
        state_d   = vdi_pkg::S_CHECK;
      end
      vdi_pkg::S_CHECK: begin
        if (slot_hit) begin
          res_d   = '{vertex_index: ram_rd_data.index, status: vdi_pkg::STATUS_FOUND};
          state_d = vdi_pkg::S_RESULT;
        end else if (!slot_used) begin
          if (count_q == TABLE_FULL || next_q == INDEX_END) begin
            res_d   = '{vertex_index: '0, status: vdi_pkg::STATUS_FULL};
            state_d = vdi_pkg::S_RESULT;
          end else begin
            state_d = vdi_pkg::S_WRITE;
          end
        end else if (probes_inc == TABLE_FULL) begin
          // every slot holds another key
          res_d   = '{vertex_index: '0, status: vdi_pkg::STATUS_FULL};
          state_d = vdi_pkg::S_RESULT;
        end else begin
          probes_d = probes_inc;
          addr_d   = addr_inc;
          state_d  = vdi_pkg::S_PROBE;
        end
      end
      vdi_pkg::S_WRITE: begin
        // claim the empty slot for the new vertex
        ram_wr_en         = 1'b1;
        ram_wr_data.epoch = epoch_q;
        ram_wr_data.index = next_q[vdi_pkg::IDX_W-1:0];
        ram_wr_data.key   = key_q;
        count_d           = count_q + CW'(1);
        next_d            = next_q + NW'(1);
        res_d   = '{vertex_index: next_q[vdi_pkg::IDX_W-1:0], status: vdi_pkg::STATUS_NEW};
        state_d = vdi_pkg::S_RESULT;
      end
      vdi_pkg::S_RESULT: begin
        if (ld_ready) begin
          state_d = vdi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = vdi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vdi_pkg::S_INIT;
      addr_q   <= '0;
      probes_q <= '0;
      count_q  <= '0;
      next_q   <= '0;
      epoch_q  <= vdi_pkg::EPOCH_FIRST;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      probes_q <= probes_d;
      count_q  <= count_d;
      next_q   <= next_d;
      epoch_q  <= epoch_d;
    end
  end

  // captured key and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= key_c;
      home_q <= home_c;
    end
    res_q <= res_d;
  end

  vdi_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (ram_rd_data)
  );

  vdi_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ld_valid_i     (state_q == vdi_pkg::S_RESULT),
    .ld_data_i      (res_q),
    .ld_ready_o     (ld_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_index_o (vertex_index_o),
    .status_o       (status_o)
  );

`ifndef ASSERT_OFF
  // live epochs never collide with the empty tag
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != vdi_pkg::EPOCH_EMPTY)
    else $error("epoch tag reached the empty code");

  // fill count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TABLE_FULL)
    else $error("fill count beyond table size");

  // an insert only happens with room in table and index space
  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vdi_pkg::S_WRITE |-> (count_q < TABLE_FULL) && (next_q < INDEX_END))
    else $error("insert while full");

  // each insert advances the global index by one
  a_write_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vdi_pkg::S_WRITE |=> next_q == $past(next_q) + NW'(1))
    else $error("index counter did not advance on insert");

  // probing never revisits the whole table
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == vdi_pkg::S_PROBE |-> probes_q < TABLE_FULL)
    else $error("probe count overran the table");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench of the vertex dedup indexer.
module tb;

  localparam int unsigned TABLE_SIZE  = 4096;
  localparam int unsigned INDEX_SPACE = 65536;
  // Far above the worst probe chains of the short meshes under the heaviest stalls
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned TAIL_CYCLES = 64;

  // Index predictor and store of pending results
  class dedup_scoreboard;
    bit [15:0]   index_by_key [bit [255:0]];
    int unsigned next_vertex_index = 0;
    int unsigned mesh_entries      = 0;
    logic [15:0] pending_index_q[$];
    logic [1:0]  pending_status_q[$];
    int unsigned mismatches  = 0;
    int unsigned checked     = 0;
    int unsigned found_count = 0;
    int unsigned new_count   = 0;
    int unsigned full_count  = 0;

    // Queue one expected result word
    function void add_expected(logic [15:0] idx, logic [1:0] status);
      pending_index_q.insert(pending_index_q.size(), idx);
      pending_status_q.insert(pending_status_q.size(), status);
    endfunction

    // Work out the result of one accepted input word
    function void note_vertex(bit sof, bit [255:0] key);
      if (sof) begin
        index_by_key.delete();
        mesh_entries = 0;
      end
      if (index_by_key.exists(key)) begin
        add_expected(index_by_key[key], vdi_pkg::STATUS_FOUND);
      end else if (mesh_entries >= TABLE_SIZE || next_vertex_index >= INDEX_SPACE) begin
        add_expected(16'd0, vdi_pkg::STATUS_FULL);
      end else begin
        index_by_key[key] = 16'(next_vertex_index);
        mesh_entries++;
        add_expected(16'(next_vertex_index), vdi_pkg::STATUS_NEW);
        next_vertex_index++;
      end
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(logic [15:0] idx, logic [1:0] status);
      logic [15:0] exp_idx;
      logic [1:0]  exp_status;
      if (pending_index_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: index %0d status %0d", idx, status);
        return;
      end
      exp_idx    = pending_index_q.pop_front();
      exp_status = pending_status_q.pop_front();
      checked++;
      case (exp_status)
        vdi_pkg::STATUS_FOUND: found_count++;
        vdi_pkg::STATUS_NEW:   new_count++;
        default:               full_count++;
      endcase
      if (idx !== exp_idx || status !== exp_status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: index exp %0d got %0d, status exp %0d got %0d",
                   checked, exp_idx, idx, exp_status, status);
      end
    endfunction

    function int unsigned pending();
      return pending_index_q.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_stall_o;
  logic         start_of_mesh_i;
  logic [255:0] vertex_key;
  logic         out_valid_o;
  logic         out_stall_i;
  logic [15:0]  vertex_index_o;
  logic [1:0]   status_o;

  dedup_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     items_sent;
  int unsigned     mesh_starts;
  int unsigned     cycle_count;

  vertex_dedup_indexer #(
    .TABLE_ENTRIES(TABLE_SIZE),
    .INDEX_LIMIT  (INDEX_SPACE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_of_mesh_i(start_of_mesh_i),
    .pos_x_i        (vertex_key[255:224]),
    .pos_y_i        (vertex_key[223:192]),
    .pos_z_i        (vertex_key[191:160]),
    .tex_u_i        (vertex_key[159:128]),
    .tex_v_i        (vertex_key[127:96]),
    .norm_x_i       (vertex_key[95:64]),
    .norm_y_i       (vertex_key[63:32]),
    .norm_z_i       (vertex_key[31:0]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_index_o (vertex_index_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall, changed on the falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(vertex_index_o, status_o);
  end

  // Float patterns that matter: signed zeros, infinities, NaNs, one, all ones
  function automatic bit [31:0] float_word();
    bit [31:0] special [8] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                               32'h7FC00000, 32'h3F800000, 32'hFFFFFFFF, 32'h00000001};
    if ($urandom_range(3) == 0)
      return special[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic bit [255:0] mixed_key();
    bit [255:0] key;
    for (int w = 0; w < 8; w++)
      key[w*32 +: 32] = float_word();
    return key;
  endfunction

  function automatic bit [255:0] fresh_key();
    bit [255:0] key;
    for (int w = 0; w < 8; w++)
      key[w*32 +: 32] = $urandom;
    return key;
  endfunction

  // Present one vertex word and hold it until taken
  task automatic send_vertex(input bit sof, input bit [255:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    start_of_mesh_i <= sof;
    vertex_key      <= key;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_vertex(sof, key);
    items_sent++;
    if (sof)
      mesh_starts++;
  endtask

  // Sender holds off until every pending result is back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_directed();
    bit [255:0] one_field;
    send_vertex(1'b1, {8{32'h00000000}});
    send_vertex(1'b0, {8{32'h00000000}});
    send_vertex(1'b0, {8{32'hFFFFFFFF}});
    // negative zero differs from positive zero
    send_vertex(1'b0, {32'h80000000, {7{32'h00000000}}});
    send_vertex(1'b0, {32'h00000000, 32'h80000000, {6{32'h00000000}}});
    // NaNs match only the same bit pattern
    send_vertex(1'b0, {8{32'h7FC00000}});
    send_vertex(1'b0, {8{32'h7FC00001}});
    send_vertex(1'b0, {8{32'h7FC00000}});
    // each field alone decides a miss
    for (int f = 0; f < 8; f++) begin
      one_field = '0;
      one_field[f*32 +: 32] = 32'hFFFFFFFF;
      send_vertex(1'b0, one_field);
    end
    send_vertex(1'b0, {8{32'hAAAAAAAA}});
    send_vertex(1'b0, {8{32'h55555555}});
    send_vertex(1'b0, {8{32'hFFFFFFFF}});
    // new mesh forgets old keys, numbering goes on
    send_vertex(1'b1, {8{32'hFFFFFFFF}});
    send_vertex(1'b0, {8{32'h00000000}});
    send_vertex(1'b1, {8{32'h00000000}});
    send_vertex(1'b0, {8{32'h00000000}});
    send_vertex(1'b0, {8{32'h7F800000}});
  endtask

  // Meshes of mostly small size with repeats, near misses and stray mesh starts
  task automatic run_random_meshes(input int unsigned item_total);
    bit [255:0]  mesh_pool[$];
    bit [255:0]  older_pool[$];
    bit [255:0]  key;
    bit          sof;
    int unsigned sent;
    int unsigned mesh_len;
    sent = 0;
    while (sent < item_total) begin
      mesh_len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(30, 1);
      if (mesh_pool.size() != 0)
        older_pool = mesh_pool;
      mesh_pool.delete();
      for (int unsigned pos = 0; pos < mesh_len && sent < item_total; pos++) begin
        sof = (pos == 0) || ($urandom_range(49) == 0);
        case ($urandom_range(9))
          0, 1, 2, 3: key = fresh_key();
          4, 5, 6: key = (mesh_pool.size() != 0) ?
                         mesh_pool[$urandom_range(mesh_pool.size() - 1)] : mixed_key();
          7: begin
            key = (mesh_pool.size() != 0) ?
                  mesh_pool[$urandom_range(mesh_pool.size() - 1)] : mixed_key();
            key[$urandom_range(255)] ^= 1'b1;
          end
          8: key = (older_pool.size() != 0) ?
                   older_pool[$urandom_range(older_pool.size() - 1)] : mixed_key();
          default: key = mixed_key();
        endcase
        mesh_pool.insert(mesh_pool.size(), key);
        send_vertex(sof, key);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    items_sent      = 0;
    mesh_starts     = 0;
    in_valid_i      = 1'b0;
    start_of_mesh_i = 1'b0;
    vertex_key      = '0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 63;
    run_directed();
    wait_for_results();
    run_random_meshes(570);
    wait_for_results();

    send_idle_pct = 63;
    recv_idle_pct = 12;
    run_random_meshes(570);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_meshes(570);
    wait_for_results();

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d vertex words in %0d mesh starts over %0d cycles.",
             items_sent, mesh_starts, cycle_count);
    $display("Checked %0d results: %0d found, %0d new, %0d full; %0d mismatches.",
             sb.checked, sb.found_count, sb.new_count, sb.full_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
